### rtl/ids_pkg.sv
`timescale 1ns / 1ps
package ids_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLES_PER_BIT = 2'd0,
    CFG_MANCHESTER      = 2'd1,
    CFG_INVERT          = 2'd2
  } cfg_idx_t;

  localparam logic [CFG_DATA_W-1:0] SPB_RESET = 16'd2560;

  // Fixed point of the bit length
  localparam int FRAC_BITS = 8;

  // Datapath widths
  localparam int SUM_W = 32;
  localparam int RES_W = 32;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] spb_q8;
    logic                  manchester;
    logic                  invert;
  } cfg_t;

endpackage

### rtl/ids_in_if.sv
`timescale 1ns / 1ps
interface ids_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           restart;

  modport source (output valid, sample, restart, input ready);
  modport sink   (input valid, sample, restart, output ready);
endinterface

### rtl/ids_out_if.sv
`timescale 1ns / 1ps
interface ids_out_if;
  logic valid;
  logic ready;
  logic bit_value;

  modport source (output valid, bit_value, input ready);
  modport sink   (input valid, bit_value, output ready);
endinterface

### rtl/ids_cfg_regs.sv
`timescale 1ns / 1ps
module ids_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ids_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ids_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output ids_pkg::cfg_t                    cfg
);

  ids_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spb_q8     <= ids_pkg::SPB_RESET;
      cfg_r.manchester <= 1'b0;
      cfg_r.invert     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ids_pkg::CFG_SAMPLES_PER_BIT: cfg_r.spb_q8     <= cfg_wdata;
        ids_pkg::CFG_MANCHESTER:      cfg_r.manchester <= cfg_wdata[0];
        ids_pkg::CFG_INVERT:          cfg_r.invert     <= cfg_wdata[0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/ids_in_stage.sv
`timescale 1ns / 1ps
module ids_in_stage #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_restart,
  input  logic                           advance,
  output logic                           s0_valid,
  output logic signed [SAMPLE_WIDTH-1:0] s0_sample,
  output logic                           s0_restart
);

  logic                           valid_r;
  logic                           valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] sample_r;
  logic                           restart_r;
  logic                           take;

  // Stage is free when empty or when its item moves on this cycle
  assign in_ready = !valid_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sample_r  <= in_sample;
      restart_r <= in_restart;
    end
  end

  assign s0_valid   = valid_r;
  assign s0_sample  = sample_r;
  assign s0_restart = restart_r;

endmodule

### rtl/ids_core.sv
`timescale 1ns / 1ps
module ids_core #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ids_pkg::cfg_t                  cfg,
  input  logic                           s0_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] s0_sample,
  input  logic                           s0_restart,
  output logic                           advance,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           out_bit
);

  localparam int SW     = SAMPLE_WIDTH + 1;       // room for a negated minimum
  localparam int WIDE_W = ids_pkg::SUM_W + 2;
  localparam logic signed [WIDE_W-1:0] SUM_MAX =
    WIDE_W'({1'b0, {(ids_pkg::SUM_W-1){1'b1}}});
  localparam logic signed [WIDE_W-1:0] SUM_MIN = -SUM_MAX - WIDE_W'(1);
  localparam logic [ids_pkg::RES_W-1:0] ONE_SAMPLE =
    ids_pkg::RES_W'(1) << ids_pkg::FRAC_BITS;

  logic signed [ids_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [ids_pkg::RES_W-1:0]        res_r, res_nxt;
  logic                             open_r, open_nxt;
  logic                             first_r, first_nxt;
  logic                             out_valid_r;
  logic                             out_bit_r;

  logic signed [SW-1:0]             s_val;
  logic signed [ids_pkg::SUM_W-1:0] sum0;
  logic [ids_pkg::RES_W-1:0]        res0, res1, res2, spb_ext;
  logic                             open0, first0, first1;
  logic signed [WIDE_W-1:0]         sum_wide;
  logic signed [ids_pkg::SUM_W-1:0] sum_sat;
  logic                             half_end;
  logic                             emit;
  logic                             bit_calc;

  assign spb_ext = ids_pkg::RES_W'(cfg.spb_q8);

  always_comb begin
    s_val = SW'(s0_sample);
    if (cfg.invert) begin
      s_val = -s_val;
    end

    // restart wipes the running bit before this sample counts
    sum0   = s0_restart ? '0 : sum_r;
    res0   = s0_restart ? '0 : res_r;
    open0  = s0_restart ? 1'b0 : open_r;
    first0 = s0_restart ? 1'b0 : first_r;

    if (!open0) begin
      res1   = res0 + spb_ext;
      first1 = cfg.manchester;
    end else begin
      res1   = res0;
      first1 = first0;
    end

    if (first1) begin
      sum_wide = WIDE_W'(sum0) - WIDE_W'(s_val);
    end else begin
      sum_wide = WIDE_W'(sum0) + WIDE_W'(s_val);
    end

    if (sum_wide > SUM_MAX) begin
      sum_sat = SUM_MAX[ids_pkg::SUM_W-1:0];
    end else if (sum_wide < SUM_MIN) begin
      sum_sat = SUM_MIN[ids_pkg::SUM_W-1:0];
    end else begin
      sum_sat = sum_wide[ids_pkg::SUM_W-1:0];
    end

    res2     = res1 - ONE_SAMPLE;
    half_end = res2[ids_pkg::RES_W-1] || (res2 == '0);
    bit_calc = !sum_sat[ids_pkg::SUM_W-1];
    emit     = half_end && !first1;

    sum_nxt   = sum_sat;
    res_nxt   = res2;
    open_nxt  = 1'b1;
    first_nxt = first1;
    if (half_end) begin
      if (first1) begin
        // second Manchester half opens on the same sample
        first_nxt = 1'b0;
        res_nxt   = res2 + spb_ext;
      end else begin
        sum_nxt  = '0;
        open_nxt = 1'b0;
      end
    end
  end

  // A non-emitting sample may pass a stalled result
  assign advance = s0_valid && (!emit || !out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      res_r       <= '0;
      open_r      <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        sum_r   <= sum_nxt;
        res_r   <= res_nxt;
        open_r  <= open_nxt;
        first_r <= first_nxt;
      end
      if (advance && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_bit_r <= bit_calc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_bit   = out_bit_r;

endmodule

### rtl/integrate_dump_bit_slicer_unit.sv
`timescale 1ns / 1ps
// Integrate-and-dump bit slicer. Each transfer on in_ch carries one signed
// sample (optionally negated) that is added to a saturating 32-bit sum, or
// subtracted from it during the first half of a Manchester bit. The bit length
// (the half length in Manchester mode) is spb_q8 in Q8.8; a
// residual tracks fractional boundaries. At the end of each bit one transfer
// on out_ch carries bit_value = (sum >= 0); a sample with restart set drops the
// partial bit and starts a new grid there.
// One sample is taken per clock unless a bit-closing sample is stalled: an
// input register feeds one pass of add/saturate and residual compare into the
// result register. Only a sample that closes a bit waits on a result still
// held in the output register. Configuration is written through cfg_we/
// cfg_index/cfg_wdata, by the user only while the block is idle (unchecked).
module integrate_dump_bit_slicer_unit #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  ids_in_if.sink                             in_ch,
  ids_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [ids_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ids_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  ids_pkg::cfg_t                  cfg;
  logic                           advance;
  logic                           s0_valid;
  logic signed [SAMPLE_WIDTH-1:0] s0_sample;
  logic                           s0_restart;

  ids_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ids_in_stage #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_sample  (in_ch.sample),
    .in_restart (in_ch.restart),
    .advance    (advance),
    .s0_valid   (s0_valid),
    .s0_sample  (s0_sample),
    .s0_restart (s0_restart)
  );

  ids_core #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .s0_valid   (s0_valid),
    .s0_sample  (s0_sample),
    .s0_restart (s0_restart),
    .advance    (advance),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_bit    (out_ch.bit_value)
  );

endmodule

### rtl/ids_checker.sv
`timescale 1ns / 1ps
module ids_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_bit_value
);

  // result held until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped without transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_bit_value))
    else $error("out bit_value changed while stalled");

  // nothing pending downstream means the input side must be open
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with free result slot");

  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind integrate_dump_bit_slicer_unit ids_checker u_ids_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_bit_value (out_ch.bit_value)
);
